### sv/ilpq_pkg.sv
// ----------------------------------------------------------------------------
// ilpq_pkg: shared types and constants
// Operation codes, status codes, sequencer states and the memory control
// group that is used by the list priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ilpq_pkg;

  // Operation codes carried in the low bits of the input word.
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_PREPEND = 3'd1;
  localparam logic [2:0] OP_INSERT  = 3'd2;
  localparam logic [2:0] OP_POP     = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Width of the count and capacity fields on the ports.
  localparam int unsigned COUNT_BITS = 9;
  localparam logic [COUNT_BITS-1:0] CAP_RESET = 9'd256;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_WALK_CMP,
    S_PUT_CHK,
    S_FREE_UPD,
    S_PUT_WR1,
    S_PUT_WR2,
    S_POP_RD,
    S_POP_UPD,
    S_POP_WR,
    S_DONE
  } seq_state_t;

  // Strobes from the sequencer to the slot memory.
  typedef struct packed {
    logic rd_en;
    logic next_we;
    logic data_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

### sv/ilpq_slot_mem.sv
// ----------------------------------------------------------------------------
// ilpq_slot_mem: slot storage
// Forward links, payloads and priorities of the pool slots. One write port
// per array and one shared read address with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilpq_slot_mem #(
  parameter int unsigned POOL = 258,
  parameter int unsigned AW   = 9,
  parameter int unsigned PB   = 32,
  parameter int unsigned PRB  = 16
) (
  input  wire logic               clk,
  input  wire ilpq_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]      rd_addr,
  input  wire logic [AW-1:0]      next_wa,
  input  wire logic [AW-1:0]      next_wd,
  input  wire logic [AW-1:0]      data_wa,
  input  wire logic [PB-1:0]      payload_wd,
  input  wire logic [PRB-1:0]     prio_wd,
  output logic [AW-1:0]           next_rd,
  output logic [PB-1:0]           payload_rd,
  output logic [PRB-1:0]          prio_rd
);
  import ilpq_pkg::*;

  logic [AW-1:0]  next_mem [POOL];
  logic [PB-1:0]  pay_mem  [POOL];
  logic [PRB-1:0] prio_mem [POOL];

  // Link array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (ctl.rd_en) begin
      next_rd <= next_mem[rd_addr];
    end
  end

  // Entry data arrays share the write address of a new entry.
  always_ff @(posedge clk) begin
    if (ctl.data_we) begin
      pay_mem[data_wa]  <= payload_wd;
      prio_mem[data_wa] <= prio_wd;
    end
    if (ctl.rd_en) begin
      payload_rd <= pay_mem[rd_addr];
      prio_rd    <= prio_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/ilpq_seq.sv
// ----------------------------------------------------------------------------
// ilpq_seq: list sequencer
// Runs one operation at a time over the slot memory: walks the list with
// the shared priority comparator, allocates and frees slots and keeps the
// head links, the count and the high-water mark.
// ----------------------------------------------------------------------------
`default_nettype none

module ilpq_seq #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned AW    = 9,
  parameter int unsigned CW    = 9,
  parameter int unsigned KW    = 9,
  parameter int unsigned PB    = 32,
  parameter int unsigned PRB   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         op,
  input  wire logic [PB-1:0]      payload_in,
  input  wire logic [PRB-1:0]     priority_in,
  input  wire logic [KW-1:0]      cap_eff,
  input  wire logic               out_free,
  output logic                    res_valid,
  output logic [1:0]              res_status,
  output logic [CW-1:0]           res_count,
  output logic [PB-1:0]           res_payload,
  output ilpq_pkg::mem_ctl_t      ctl,
  output logic [AW-1:0]           rd_addr,
  output logic [AW-1:0]           next_wa,
  output logic [AW-1:0]           next_wd,
  output logic [AW-1:0]           data_wa,
  output logic [PB-1:0]           payload_wd,
  output logic [PRB-1:0]          prio_wd,
  input  wire logic [AW-1:0]      next_rd,
  input  wire logic [PB-1:0]      payload_rd,
  input  wire logic [PRB-1:0]     prio_rd
);
  import ilpq_pkg::*;

  localparam logic [AW-1:0] HEAD_USED = AW'(0);
  localparam logic [AW-1:0] HEAD_FREE = AW'(1);

  seq_state_t state, state_next;

  logic [2:0]     op_r;
  logic [PB-1:0]  pay_r;
  logic [PRB-1:0] prio_r;
  logic [AW-1:0]  p, n, f;
  logic [AW-1:0]  used_next, used_prev, free_next, free_prev;
  logic [AW:0]    hwm;
  logic [CW-1:0]  count;
  logic [1:0]     status_r;
  logic [PB-1:0]  pay_out;

  logic start;
  logic ge;
  logic full;

  assign start = in_valid && in_ready;
  // Shared comparator: stored priority against the new one.
  assign ge   = $signed(prio_rd) >= $signed(prio_r);
  assign full = KW'(count) >= cap_eff;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_APPEND, OP_PREPEND: state_next = S_PUT_CHK;
            OP_INSERT:             state_next = S_WALK;
            OP_POP:   state_next = (used_next == HEAD_USED) ? S_DONE : S_POP_RD;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_WALK:     state_next = (n == HEAD_USED) ? S_PUT_CHK : S_WALK_CMP;
      S_WALK_CMP: state_next = ge ? S_WALK : S_PUT_CHK;
      S_PUT_CHK: begin
        if (full) begin
          state_next = S_DONE;
        end else if (free_next == HEAD_FREE) begin
          state_next = S_PUT_WR1;
        end else begin
          state_next = S_FREE_UPD;
        end
      end
      S_FREE_UPD: state_next = S_PUT_WR1;
      S_PUT_WR1:  state_next = S_PUT_WR2;
      S_PUT_WR2:  state_next = S_DONE;
      S_POP_RD:   state_next = S_POP_UPD;
      S_POP_UPD:  state_next = S_POP_WR;
      S_POP_WR:   state_next = S_DONE;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory strobes and addresses.
  always_comb begin
    ctl        = '0;
    rd_addr    = n;
    next_wa    = f;
    next_wd    = n;
    data_wa    = f;
    payload_wd = pay_r;
    prio_wd    = (op_r == OP_INSERT) ? prio_r : '0;
    case (state)
      S_WALK: begin
        ctl.rd_en = (n != HEAD_USED);
      end
      S_PUT_CHK: begin
        rd_addr   = free_next;
        ctl.rd_en = !full && (free_next != HEAD_FREE);
      end
      S_PUT_WR1: begin
        ctl.data_we = 1'b1;
        ctl.next_we = 1'b1;
      end
      S_PUT_WR2: begin
        next_wa     = p;
        next_wd     = f;
        ctl.next_we = (p != HEAD_USED);
      end
      S_POP_RD: begin
        rd_addr   = f;
        ctl.rd_en = 1'b1;
      end
      S_POP_UPD: begin
        next_wd     = HEAD_FREE;
        ctl.next_we = 1'b1;
      end
      S_POP_WR: begin
        next_wa     = free_prev;
        next_wd     = f;
        ctl.next_we = (free_prev != HEAD_FREE);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    in_ready    = (state == S_IDLE);
    res_valid   = (state == S_DONE) && out_free;
    res_status  = status_r;
    res_count   = count;
    res_payload = pay_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used_next <= HEAD_USED;
      used_prev <= HEAD_USED;
      free_next <= HEAD_FREE;
      free_prev <= HEAD_FREE;
      hwm       <= (AW+1)'(2);
      count     <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r     <= op;
            pay_r    <= payload_in;
            prio_r   <= priority_in;
            status_r <= (op == OP_POP && used_next == HEAD_USED) ? ST_EMPTY : ST_OK;
            pay_out  <= '0;
            case (op)
              OP_APPEND: begin
                p <= used_prev;
                n <= HEAD_USED;
              end
              OP_PREPEND, OP_INSERT: begin
                p <= HEAD_USED;
                n <= used_next;
              end
              OP_POP: begin
                f <= used_next;
              end
              OP_CLEAR: begin
                used_next <= HEAD_USED;
                used_prev <= HEAD_USED;
                free_next <= HEAD_FREE;
                free_prev <= HEAD_FREE;
                hwm       <= (AW+1)'(2);
                count     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        // Step past an entry of greater or equal priority.
        S_WALK_CMP: begin
          if (ge) begin
            p <= n;
            n <= next_rd;
          end
        end
        // Take a slot from the free list or from the high-water mark.
        S_PUT_CHK: begin
          if (full) begin
            status_r <= ST_FULL;
          end else if (free_next == HEAD_FREE) begin
            f   <= hwm[AW-1:0];
            hwm <= hwm + 1'b1;
          end else begin
            f <= free_next;
          end
        end
        S_FREE_UPD: begin
          free_next <= next_rd;
          if (next_rd == HEAD_FREE) begin
            free_prev <= HEAD_FREE;
          end
        end
        S_PUT_WR1: begin
          if (n == HEAD_USED) begin
            used_prev <= f;
          end
        end
        S_PUT_WR2: begin
          if (p == HEAD_USED) begin
            used_next <= f;
          end
          count <= count + 1'b1;
        end
        // Unlink the head entry and hand back its payload.
        S_POP_UPD: begin
          used_next <= next_rd;
          if (next_rd == HEAD_USED) begin
            used_prev <= HEAD_USED;
          end
          pay_out <= payload_rd;
        end
        S_POP_WR: begin
          if (free_prev == HEAD_FREE) begin
            free_next <= f;
          end
          free_prev <= f;
          count     <= count - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The count never exceeds the pool.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("entry count above pool size");

  // An empty used list and a zero count go together between operations.
  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((used_next == HEAD_USED) == (count == '0)))
    else $error("used list and count disagree");

  // A clear empties the list at once.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && op == OP_CLEAR) |=> (count == '0 && used_next == HEAD_USED))
    else $error("clear did not empty the list");

  // A refused put leaves the count unchanged.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT_CHK && full) |=> $stable(count))
    else $error("count changed on refused put");

endmodule

`default_nettype wire

### sv/indexed_list_priority_queue.sv
// ----------------------------------------------------------------------------
// indexed_list_priority_queue: linked-list priority queue over a slot pool
// Input words carry an operation (append, prepend, insert by priority, pop,
// clear) with a payload and a signed priority; each input word yields one
// output word with status, entry count and popped payload.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries operations, m_axis carries one result word per operation.
//   cfg_we/cfg_wdata write the capacity limit; write only while idle.
//   From acceptance to a result in the output register, append and prepend
//   pass through S_PUT_CHK, S_FREE_UPD when a freed slot is reused,
//   S_PUT_WR1, S_PUT_WR2 and S_DONE; a pop through S_POP_RD, S_POP_UPD,
//   S_POP_WR and S_DONE; a refused put through S_PUT_CHK and S_DONE; a clear,
//   a refused pop or an unused op straight to S_DONE. Insert first walks the
//   list entry by entry (a link and priority read, then the compare).
//   s_axis_tready rises the cycle after the result is loaded.
//   The sequencer handles one operation at a time; s_axis_tready is high
//   only while it is idle. A finished result sits in the output register
//   while the next operation is accepted; if that register is still held
//   by a stalled receiver, the sequencer waits before going idle.
//   Reset empties both lists, sets the capacity to 256 and invalidates the
//   output register. No memory clearing pass is needed: the head links are
//   registers and slots are handed out through a high-water mark.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_priority_queue #(
  parameter int unsigned SLOTS         = 256,
  parameter int unsigned PAYLOAD_BITS  = 32,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // op[2:0], payload_in, priority_in, zero fill
  input  wire logic [((3+PAYLOAD_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // status[1:0], entry_count[10:2], payload_out, zero fill
  output logic [((2+ilpq_pkg::COUNT_BITS+PAYLOAD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic cfg_we,
  input  wire logic [ilpq_pkg::COUNT_BITS-1:0] cfg_wdata
);
  import ilpq_pkg::*;

  localparam int unsigned POOL = SLOTS + 2;
  localparam int unsigned AW   = $clog2(POOL);
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned KW   = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int unsigned PB   = PAYLOAD_BITS;
  localparam int unsigned PRB  = PRIORITY_BITS;
  localparam int unsigned OW   = ((2 + COUNT_BITS + PB + 7) / 8) * 8;
  localparam int unsigned RW   = 2 + COUNT_BITS + PB;

  logic [COUNT_BITS-1:0] cap_reg;
  logic [KW-1:0]         cap_k, cap_eff;
  logic                  out_free;
  logic                  res_valid;
  logic [1:0]            res_status;
  logic [CW-1:0]         res_count;
  logic [KW-1:0]         res_count_k;
  logic [PB-1:0]         res_payload;
  logic [OW-1:0]         out_word;

  mem_ctl_t       ctl;
  logic [AW-1:0]  rd_addr, next_wa, next_wd, data_wa, next_rd;
  logic [PB-1:0]  payload_wd, payload_rd;
  logic [PRB-1:0] prio_wd, prio_rd;

  // Capacity register; the effective capacity is clamped to the pool.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_wdata;
    end
  end

  assign cap_k   = KW'(cap_reg);
  assign cap_eff = (cap_k > KW'(SLOTS)) ? KW'(SLOTS) : cap_k;

  // Output register between the sequencer and the receiver.
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign res_count_k = KW'(res_count);
  assign out_word    = OW'({res_payload, res_count_k[COUNT_BITS-1:0], res_status});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= out_word;
    end
  end

  ilpq_seq #(
    .SLOTS(SLOTS), .AW(AW), .CW(CW), .KW(KW), .PB(PB), .PRB(PRB)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .op          (s_axis_tdata[2:0]),
    .payload_in  (s_axis_tdata[3+PB-1:3]),
    .priority_in (s_axis_tdata[3+PB+PRB-1:3+PB]),
    .cap_eff     (cap_eff),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res_status  (res_status),
    .res_count   (res_count),
    .res_payload (res_payload),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .next_wa     (next_wa),
    .next_wd     (next_wd),
    .data_wa     (data_wa),
    .payload_wd  (payload_wd),
    .prio_wd     (prio_wd),
    .next_rd     (next_rd),
    .payload_rd  (payload_rd),
    .prio_rd     (prio_rd)
  );

  ilpq_slot_mem #(
    .POOL(POOL), .AW(AW), .PB(PB), .PRB(PRB)
  ) u_mem (
    .clk        (clk),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .next_wa    (next_wa),
    .next_wd    (next_wd),
    .data_wa    (data_wa),
    .payload_wd (payload_wd),
    .prio_wd    (prio_wd),
    .next_rd    (next_rd),
    .payload_rd (payload_rd),
    .prio_rd    (prio_rd)
  );

  // A new result never overwrites one the receiver has not taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !res_valid)
    else $error("result overwrote a pending word");

  // A stalled result word holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(m_axis_tvalid && !m_axis_tready) && !$past(rst) |-> $stable(m_axis_tdata))
    else $error("pending word changed");

  // The effective capacity never exceeds the pool.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    cap_eff <= KW'(SLOTS))
    else $error("capacity above pool");

endmodule

`default_nettype wire

### tb/sv/tb_indexed_list_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_priority_queue: regression for the list priority queue
// Drives operation words with random idling on both sides and compares each
// result word with a behavioral list model kept as SystemVerilog queues.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_indexed_list_priority_queue;
  import ilpq_pkg::*;

  localparam int SLOTS = 256;
  localparam int IW = ((3 + 32 + 16 + 7) / 8) * 8;
  localparam int OW = ((2 + COUNT_BITS + 32 + 7) / 8) * 8;

  typedef struct {
    logic [1:0]  status;
    logic [8:0]  entry_count;
    logic [31:0] payload_out;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;

  // Model of the list: payloads and priorities from head to tail.
  logic [31:0] list_payload[$];
  logic signed [15:0] list_prio[$];
  logic [8:0] cap_reg;
  result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  indexed_list_priority_queue dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the list model and return its result word.
  function automatic result_t predict_queue_op(logic [2:0] op, logic [31:0] pay,
                                               logic signed [15:0] pri);
    result_t r;
    int limit;
    int pos;
    r = '{ST_OK, 9'd0, 32'd0};
    limit = (cap_reg > SLOTS) ? SLOTS : cap_reg;
    if (op == OP_APPEND || op == OP_PREPEND || op == OP_INSERT) begin
      if (list_payload.size() >= limit) begin
        r.status = ST_FULL;
      end else if (op == OP_APPEND) begin
        list_payload.push_back(pay);
        list_prio.push_back(16'sd0);
      end else if (op == OP_PREPEND) begin
        list_payload.push_front(pay);
        list_prio.push_front(16'sd0);
      end else begin
        pos = 0;
        while (pos < list_prio.size() && list_prio[pos] >= pri) pos++;
        list_payload.insert(pos, pay);
        list_prio.insert(pos, pri);
      end
    end else if (op == OP_POP) begin
      if (list_payload.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.payload_out = list_payload.pop_front();
        void'(list_prio.pop_front());
      end
    end else if (op == OP_CLEAR) begin
      list_payload.delete();
      list_prio.delete();
    end
    r.entry_count = 9'(list_payload.size());
    return r;
  endfunction

  // Send one word, idling first at the current rate. The word stays valid
  // after acceptance until the next falling edge, where the next call or
  // wait_drained takes it down.
  task automatic send_op(logic [2:0] op, logic [31:0] pay, logic signed [15:0] pri);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= IW'({pri, pay, op});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_queue_op(op, pay, pri));
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    // Allow the longest insert walk to finish before touching the register.
    repeat (600) @(negedge clk);
  endtask

  task automatic write_capacity(logic [8:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_reg = value;
  endtask

  // Receiver side: stall at random and check each accepted word.
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[10:2] !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, m_axis_tdata[10:2]);
          errors++;
        end
        if (m_axis_tdata[42:11] !== e.payload_out) begin
          $error("payload_out: expected %h, got %h", e.payload_out, m_axis_tdata[42:11]);
          errors++;
        end
      end
    end
  end

  // Corner words: empty pop, all ops, field extremes, equal priorities, unused ops.
  task automatic test_directed();
    send_op(OP_POP, 32'hFFFF_FFFF, 16'sh7FFF);
    send_op(OP_APPEND, 32'hFFFF_FFFF, 16'sh7FFF);
    send_op(OP_PREPEND, 32'h0000_0000, -16'sh8000);
    send_op(OP_INSERT, 32'hA5A5_0001, 16'sh7FFF);
    send_op(OP_INSERT, 32'hA5A5_0002, 16'sh7FFF);
    send_op(OP_INSERT, 32'hA5A5_0003, -16'sh8000);
    send_op(OP_INSERT, 32'hA5A5_0004, 16'sd0);
    send_op(OP_INSERT, 32'h5A5A_0005, -16'sd1);
    send_op(3'd5, 32'h1234_5678, 16'sd5);
    send_op(3'd6, 32'h0, 16'sd0);
    send_op(3'd7, 32'hFFFF_FFFF, -16'sd1);
    repeat (5) send_op(OP_POP, 32'h0, 16'sd0);
    send_op(OP_CLEAR, 32'hDEAD_BEEF, 16'sd3);
    send_op(OP_POP, 32'h0, 16'sd0);
    send_op(OP_APPEND, 32'h0000_0011, 16'sd0);
    send_op(OP_CLEAR, 32'h0, 16'sd0);
  endtask

  // Small capacities: full refusals, capacity zero and lowered below count.
  task automatic test_capacity();
    write_capacity(9'd1);
    send_op(OP_APPEND, 32'h1, 16'sd0);
    send_op(OP_INSERT, 32'h2, 16'sd9);
    send_op(OP_PREPEND, 32'h3, 16'sd0);
    write_capacity(9'd0);
    send_op(OP_APPEND, 32'h4, 16'sd0);
    send_op(OP_POP, 32'h0, 16'sd0);
    write_capacity(9'd4);
    repeat (4) send_op(OP_APPEND, $urandom, 16'sd0);
    write_capacity(9'd2);
    send_op(OP_INSERT, 32'h5, 16'sd1);
    send_op(OP_POP, 32'h0, 16'sd0);
    write_capacity(9'd511);
    send_op(OP_CLEAR, 32'h0, 16'sd0);
  endtask

  // Random mix biased toward puts so the list grows and reuses freed slots.
  task automatic test_random(int count, int idle, int stall, int fill_bias);
    int k;
    logic [2:0] op;
    logic signed [15:0] pri;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < fill_bias) op = ($urandom_range(3) == 0) ? 3'($urandom_range(1)) : OP_INSERT;
      else if (k < 97) op = OP_POP;
      else if (k < 99) op = OP_CLEAR;
      else op = 3'($urandom_range(7, 5));
      // Narrow priorities often, so equal values and FIFO order get exercised.
      pri = ($urandom_range(1)) ? $signed(16'($urandom)) : 16'($signed($urandom_range(6)) - 3);
      send_op(op, $urandom, pri);
    end
  endtask

  // Fill a full pool, pausing until all results are back.
  task automatic test_full_pool();
    write_capacity(9'd256);
    send_op(OP_CLEAR, 32'h0, 16'sd0);
    for (int i = 0; i < 258; i++)
      send_op((i % 2) ? OP_APPEND : OP_INSERT, $urandom, 16'($urandom));
    wait_drained();
    repeat (260) send_op(OP_POP, 32'h0, 16'sd0);
  endtask

  initial begin
    cap_reg = CAP_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_capacity();
    test_random(200, 0, 0, 70);
    write_capacity(9'd17);
    test_random(200, 80, 0, 60);
    write_capacity(9'd300);
    test_random(200, 0, 80, 55);
    write_capacity(9'd256);
    test_random(200, 15, 15, 65);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_full_pool();
    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("indexed_list_priority_queue regression: pass");
    end else begin
      $display("indexed_list_priority_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("indexed_list_priority_queue regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
